// ----- rtl/mpwm_pkg.sv -----
`default_nettype none

package mpwm_pkg;

    // Field widths fixed by the command format
    localparam int CHAN_W    = 5;
    localparam int DUTY_W    = 5;
    localparam int DUTY_IN_W = 8;
    localparam int PAT_W     = 32;
    localparam int CNT_W     = 6;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 5'h1F;

    localparam logic KIND_PATTERN  = 1'b0;
    localparam logic KIND_READBACK = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_SET_DUTY    = 2'd1,
        CMD_SET_PATTERN = 2'd2,
        CMD_READ        = 2'd3
    } mpwm_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SWEEP,
        ST_READ
    } mpwm_state_t;

    // Request from the sequencer to the duty memory
    typedef struct packed {
        logic              wr_en;
        logic [CHAN_W-1:0] wr_addr;
        logic [DUTY_W-1:0] wr_data;
        logic              rd_en;
        logic [CHAN_W-1:0] rd_addr;
    } mpwm_mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/mpwm_duty_mem.sv -----
`default_nettype none

module mpwm_duty_mem #(
    parameter int CHANNELS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mpwm_pkg::mpwm_mem_req_t       req,
    output logic [mpwm_pkg::DUTY_W-1:0]        rdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [mpwm_pkg::DUTY_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0]         vld_reg;
    logic [mpwm_pkg::DUTY_W-1:0] data_reg;
    logic                        data_vld_reg;

    // Write the storage array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_vld_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            data_vld_reg <= vld_reg[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = data_vld_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/mpwm_seq.sv -----
`default_nettype none

module mpwm_seq #(
    parameter int CHANNELS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [mpwm_pkg::CNT_W-1:0]        active_count,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        command,
    input  wire logic [mpwm_pkg::CHAN_W-1:0]       channel,
    input  wire logic [mpwm_pkg::DUTY_IN_W-1:0]    duty_in,
    input  wire logic [mpwm_pkg::PAT_W-1:0]        pattern_in,
    output mpwm_pkg::mpwm_mem_req_t                mem_req,
    input  wire logic [mpwm_pkg::DUTY_W-1:0]       mem_rdata,
    output logic                                   strobe,
    output logic                                   result_kind,
    output logic [mpwm_pkg::PAT_W-1:0]             pattern_out,
    output logic [mpwm_pkg::DUTY_W-1:0]            duty_out
);

    localparam logic [mpwm_pkg::CNT_W-1:0] CHAN_LIMIT = mpwm_pkg::CNT_W'(CHANNELS);

    mpwm_pkg::mpwm_state_t state_reg, state_next;
    mpwm_pkg::mpwm_cmd_t   cmd;

    logic [mpwm_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [mpwm_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [mpwm_pkg::PAT_W-1:0]  levels_reg, levels_next;
    logic [mpwm_pkg::PAT_W-1:0]  pat_reg, pat_next;
    logic [mpwm_pkg::DUTY_W-1:0] phase_reg, phase_next;
    logic                        chan_ok_reg, chan_ok_next;
    logic                        strobe_reg, strobe_next;
    logic                        kind_reg, kind_next;
    logic [mpwm_pkg::PAT_W-1:0]  pat_out_reg, pat_out_next;
    logic [mpwm_pkg::DUTY_W-1:0] duty_out_reg, duty_out_next;

    logic                        accept;
    logic                        chan_in_range;
    logic [mpwm_pkg::DUTY_W-1:0] duty_sat;
    logic [mpwm_pkg::PAT_W-1:0]  levels_shift;

    assign cmd           = mpwm_pkg::mpwm_cmd_t'(command);
    assign busy          = (state_reg != mpwm_pkg::ST_IDLE);
    assign accept        = start && !busy;
    assign chan_in_range = ({1'b0, channel} < CHAN_LIMIT);
    assign duty_sat      = (duty_in > {3'b000, mpwm_pkg::DUTY_MAX}) ? mpwm_pkg::DUTY_MAX
                                                                  : duty_in[4:0];
    // Fold in the duty read back for the previous channel
    assign levels_shift  = {levels_reg[mpwm_pkg::PAT_W-2:0], (phase_reg < mem_rdata)};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpwm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        mpwm_pkg::CMD_TICK:        state_next = mpwm_pkg::ST_TICK;
                        mpwm_pkg::CMD_SET_PATTERN:
                        begin
                            if (active_count != '0)
                            begin
                                state_next = mpwm_pkg::ST_SWEEP;
                            end
                        end
                        mpwm_pkg::CMD_READ:        state_next = mpwm_pkg::ST_READ;
                        default:                   state_next = mpwm_pkg::ST_IDLE;
                    endcase
                end
            end
            mpwm_pkg::ST_TICK:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = mpwm_pkg::ST_IDLE;
                end
            end
            mpwm_pkg::ST_SWEEP:
            begin
                if (idx_reg + 1'b1 == n_reg)
                begin
                    state_next = mpwm_pkg::ST_IDLE;
                end
            end
            mpwm_pkg::ST_READ:
            begin
                state_next = mpwm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mpwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and results
    always_comb
    begin
        idx_next      = idx_reg;
        n_next        = n_reg;
        levels_next   = levels_reg;
        pat_next      = pat_reg;
        phase_next    = phase_reg;
        chan_ok_next  = chan_ok_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        pat_out_next  = pat_out_reg;
        duty_out_next = duty_out_reg;
        mem_req       = '0;

        case (state_reg)
            mpwm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    n_next       = active_count;
                    levels_next  = '0;
                    pat_next     = pattern_in;
                    chan_ok_next = chan_in_range;
                    case (cmd)
                        mpwm_pkg::CMD_TICK:
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                        mpwm_pkg::CMD_SET_DUTY:
                        begin
                            mem_req.wr_en   = chan_in_range;
                            mem_req.wr_addr = channel;
                            mem_req.wr_data = duty_sat;
                        end
                        mpwm_pkg::CMD_READ:
                        begin
                            mem_req.rd_en   = chan_in_range;
                            mem_req.rd_addr = channel;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mpwm_pkg::ST_TICK:
            begin
                // Issue the read for this channel, collect the previous one
                mem_req.rd_en   = (idx_reg < n_reg);
                mem_req.rd_addr = idx_reg[mpwm_pkg::CHAN_W-1:0];
                if (idx_reg != '0)
                begin
                    levels_next = levels_shift;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg)
                begin
                    strobe_next   = 1'b1;
                    kind_next     = mpwm_pkg::KIND_PATTERN;
                    pat_out_next  = (idx_reg != '0) ? levels_shift : '0;
                    duty_out_next = '0;
                end
            end
            mpwm_pkg::ST_SWEEP:
            begin
                // Write one channel per cycle from the pattern LSB
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[mpwm_pkg::CHAN_W-1:0];
                mem_req.wr_data = pat_reg[0] ? mpwm_pkg::DUTY_MAX : '0;
                pat_next        = pat_reg >> 1;
                idx_next        = idx_reg + 1'b1;
            end
            mpwm_pkg::ST_READ:
            begin
                strobe_next   = 1'b1;
                kind_next     = mpwm_pkg::KIND_READBACK;
                pat_out_next  = '0;
                duty_out_next = chan_ok_reg ? mem_rdata : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mpwm_pkg::ST_IDLE;
            phase_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        levels_reg   <= levels_next;
        pat_reg      <= pat_next;
        chan_ok_reg  <= chan_ok_next;
        kind_reg     <= kind_next;
        pat_out_reg  <= pat_out_next;
        duty_out_reg <= duty_out_next;
    end

    assign strobe      = strobe_reg;
    assign result_kind = kind_reg;
    assign pattern_out = pat_out_reg;
    assign duty_out    = duty_out_reg;

endmodule

`default_nettype wire

// ----- rtl/multichannel_pwm_pattern_generator.sv -----
`default_nettype none

// Multichannel PWM pattern generator: a 5-bit duty per channel, one shared
// 5-bit phase counter.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low; command, channel, duty_in and pattern_in are sampled then.
// Result channel: strobe is high for exactly one cycle with result_kind,
// pattern_out and duty_out valid; the receiver cannot stall it, so results
// are never held back and the next command may be taken while one shows.
// Commands, with n the active channel count (at most CHANNELS):
//   tick        - busy in the tick state, strobe registered after it;
//                 one duty memory read per channel.
//   set duty    - no busy time, no result.
//   set pattern - one memory write per channel while busy, no result.
//   read duty   - busy in the read state, strobe registered after it.
// channel_count is written through channel_count_we; the user must do so
// only while idle, which the block itself does not enforce. Reset clears
// the phase counter, channel_count and every stored duty (per-entry valid
// bits; no clearing sweep is needed).

module multichannel_pwm_pattern_generator #(
    parameter int CHANNELS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        channel_count_we,
    input  wire logic [5:0]  channel_count,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  channel,
    input  wire logic [7:0]  duty_in,
    input  wire logic [31:0] pattern_in,
    output logic             strobe,
    output logic             result_kind,
    output logic [31:0]      pattern_out,
    output logic [4:0]       duty_out
);

    localparam logic [mpwm_pkg::CNT_W-1:0] CHAN_LIMIT = mpwm_pkg::CNT_W'(CHANNELS);

    logic [mpwm_pkg::CNT_W-1:0]  channel_count_reg;
    logic [mpwm_pkg::CNT_W-1:0]  active_count;
    mpwm_pkg::mpwm_mem_req_t     mem_req;
    logic [mpwm_pkg::DUTY_W-1:0] mem_rdata;

    // Hold the channel count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= '0;
        end
        else if (channel_count_we)
        begin
            channel_count_reg <= channel_count;
        end
    end

    // Clamp the count to the channels built
    assign active_count = (channel_count_reg > CHAN_LIMIT) ? CHAN_LIMIT : channel_count_reg;

    mpwm_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_count (active_count),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .channel      (channel),
        .duty_in      (duty_in),
        .pattern_in   (pattern_in),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .strobe       (strobe),
        .result_kind  (result_kind),
        .pattern_out  (pattern_out),
        .duty_out     (duty_out)
    );

    mpwm_duty_mem #(
        .CHANNELS (CHANNELS)
    ) u_duty_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- verif/tb_multichannel_pwm_pattern_generator.sv -----
`timescale 1ns / 1ps

module tb_multichannel_pwm_pattern_generator;

    localparam int NUM_CH      = 32;
    localparam int SETTLE_CYC  = 40;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        mpwm_pkg::mpwm_cmd_t                  cmd;
        logic [mpwm_pkg::CHAN_W-1:0]          chan;
        logic [mpwm_pkg::DUTY_IN_W-1:0]       duty;
        logic [mpwm_pkg::PAT_W-1:0]           pat;
    } pwm_txn_t;

    typedef struct packed {
        logic                                 kind;
        logic [mpwm_pkg::PAT_W-1:0]           levels;
        logic [mpwm_pkg::DUTY_W-1:0]          duty;
    } pwm_out_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 channel_count_we;
    logic [mpwm_pkg::CNT_W-1:0]           channel_count;
    logic                                 start;
    logic                                 busy;
    logic [1:0]                           command;
    logic [mpwm_pkg::CHAN_W-1:0]          channel;
    logic [mpwm_pkg::DUTY_IN_W-1:0]       duty_in;
    logic [mpwm_pkg::PAT_W-1:0]           pattern_in;
    logic                                 strobe;
    logic                                 result_kind;
    logic [mpwm_pkg::PAT_W-1:0]           pattern_out;
    logic [mpwm_pkg::DUTY_W-1:0]          duty_out;

    // Stimulus and scoreboard storage
    pwm_txn_t  cmd_q[$];
    pwm_out_t  expected_out_q[$];
    pwm_txn_t  drv_item;
    logic      taken;
    int        idle_pct;
    int        gen_count;
    int        mismatches;

    // Shadow copy of the block state
    logic [mpwm_pkg::DUTY_W-1:0] shadow_duty[NUM_CH];
    logic [4:0]                  shadow_phase;
    logic [mpwm_pkg::CNT_W-1:0]  shadow_count;

    multichannel_pwm_pattern_generator #(
        .CHANNELS(NUM_CH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .channel_count_we (channel_count_we),
        .channel_count    (channel_count),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .channel          (channel),
        .duty_in          (duty_in),
        .pattern_in       (pattern_in),
        .strobe           (strobe),
        .result_kind      (result_kind),
        .pattern_out      (pattern_out),
        .duty_out         (duty_out)
    );

    always #4 clk = ~clk;

    // Advance the shadow state for one accepted command and queue any result
    task automatic pwm_predict(input pwm_txn_t t);
        pwm_out_t r;
        int       n;
        int       i;
        r = '0;
        n = (shadow_count > NUM_CH) ? NUM_CH : int'(shadow_count);
        case (t.cmd)
            mpwm_pkg::CMD_TICK:
            begin
                shadow_phase = shadow_phase + 5'd1;
                for (i = 0; i < n; i++)
                begin
                    r.levels = {r.levels[mpwm_pkg::PAT_W-2:0],
                                (shadow_phase < shadow_duty[i])};
                end
                r.kind = mpwm_pkg::KIND_PATTERN;
                expected_out_q.push_back(r);
            end
            mpwm_pkg::CMD_SET_DUTY:
            begin
                shadow_duty[t.chan] = (t.duty > mpwm_pkg::DUTY_MAX) ? mpwm_pkg::DUTY_MAX
                                                                    : t.duty[4:0];
            end
            mpwm_pkg::CMD_SET_PATTERN:
            begin
                for (i = 0; i < n; i++)
                begin
                    shadow_duty[i] = t.pat[i] ? mpwm_pkg::DUTY_MAX : '0;
                end
            end
            default:
            begin
                r.kind = mpwm_pkg::KIND_READBACK;
                r.duty = shadow_duty[t.chan];
                expected_out_q.push_back(r);
            end
        endcase
    endtask

    // Monitor: check results, then track config writes and accepted commands
    always @(posedge clk)
    begin
        pwm_out_t exp_r;
        if (!rst_n)
        begin
            taken <= 1'b0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_out_q.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d pattern %h duty %0d",
                             $time, result_kind, pattern_out, duty_out);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_out_q.pop_front();
                    if (result_kind !== exp_r.kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, exp_r.kind, result_kind);
                        mismatches++;
                    end
                    if (pattern_out !== exp_r.levels)
                    begin
                        $display("%0t: pattern_out expected %h actual %h",
                                 $time, exp_r.levels, pattern_out);
                        mismatches++;
                    end
                    if (duty_out !== exp_r.duty)
                    begin
                        $display("%0t: duty_out expected %0d actual %0d",
                                 $time, exp_r.duty, duty_out);
                        mismatches++;
                    end
                end
            end
            if (channel_count_we)
            begin
                shadow_count = channel_count;
            end
            if (start && !busy)
            begin
                pwm_predict(pwm_txn_t'{mpwm_pkg::mpwm_cmd_t'(command), channel, duty_in,
                                       pattern_in});
            end
            taken <= start && !busy;
        end
    end

    // Driver: hold a command until taken, then pop the next one or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                drv_item = cmd_q.pop_front();
                start <= 1'b1;
                command <= drv_item.cmd;
                channel <= drv_item.chan;
                duty_in <= drv_item.duty;
                pattern_in <= drv_item.pat;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic void add_cmd(mpwm_pkg::mpwm_cmd_t c,
                                    logic [mpwm_pkg::CHAN_W-1:0] ch,
                                    logic [mpwm_pkg::DUTY_IN_W-1:0] d,
                                    logic [mpwm_pkg::PAT_W-1:0] p);
        cmd_q.push_back(pwm_txn_t'{c, ch, d, p});
        gen_count++;
    endfunction

    // Mix in-range duties, saturating ones and the boundaries
    function automatic logic [mpwm_pkg::DUTY_IN_W-1:0] pick_duty();
        case ($urandom_range(0, 3))
            0: return mpwm_pkg::DUTY_IN_W'($urandom_range(0, 31));
            1: return mpwm_pkg::DUTY_IN_W'($urandom_range(32, 255));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd31;
                    2: return 8'd32;
                    default: return 8'd255;
                endcase
            end
            default: return mpwm_pkg::DUTY_IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [mpwm_pkg::PAT_W-1:0] pick_pattern();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            default: return $urandom();
        endcase
    endfunction

    // Ticks with random filler fields, sprinkled with readbacks
    function automatic void add_tick_run(int len);
        int k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_cmd(mpwm_pkg::CMD_READ, mpwm_pkg::CHAN_W'($urandom()),
                        mpwm_pkg::DUTY_IN_W'($urandom()), $urandom());
            else
                add_cmd(mpwm_pkg::CMD_TICK, mpwm_pkg::CHAN_W'($urandom()),
                        mpwm_pkg::DUTY_IN_W'($urandom()), $urandom());
        end
    endfunction

    // Build duty programs followed by tick bursts, plus some noise
    function automatic void gen_traffic(int total);
        int stop_at;
        int kind;
        int len;
        int k;
        stop_at = gen_count + total;
        while (gen_count < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                len = $urandom_range(2, 8);
                for (k = 0; k < len; k++)
                    add_cmd(mpwm_pkg::CMD_SET_DUTY, mpwm_pkg::CHAN_W'($urandom()),
                            pick_duty(), $urandom());
                add_tick_run($urandom_range(4, 24));
            end
            else if (kind < 7)
            begin
                add_cmd(mpwm_pkg::CMD_SET_PATTERN, mpwm_pkg::CHAN_W'($urandom()),
                        mpwm_pkg::DUTY_IN_W'($urandom()), pick_pattern());
                add_tick_run($urandom_range(4, 16));
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    add_cmd(mpwm_pkg::mpwm_cmd_t'($urandom_range(0, 3)),
                            mpwm_pkg::CHAN_W'($urandom()), pick_duty(), $urandom());
            end
        end
    endfunction

    // Let all queued work finish, then allow the longest silent command to end
    task automatic wait_drained();
        while (cmd_q.size() != 0 || start || busy || expected_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_channel_count(input logic [mpwm_pkg::CNT_W-1:0] v);
        @(negedge clk);
        channel_count_we <= 1'b1;
        channel_count <= v;
        @(negedge clk);
        channel_count_we <= 1'b0;
    endtask

    initial
    begin
        int p;
        logic [mpwm_pkg::CNT_W-1:0] phase_counts[12];
        phase_counts = '{6'd32, 6'd1, 6'd63, 6'd17, 6'd0, 6'd32,
                         6'd33, 6'd31, 6'd0, 6'd2, 6'd32, 6'd0};
        phase_counts[8] = mpwm_pkg::CNT_W'($urandom_range(0, 63));
        phase_counts[11] = mpwm_pkg::CNT_W'($urandom_range(3, 30));
        clk = 1'b0;
        rst_n = 1'b0;
        channel_count_we = 1'b0;
        channel_count = '0;
        start = 1'b0;
        command = mpwm_pkg::CMD_TICK;
        channel = '0;
        duty_in = '0;
        pattern_in = '0;
        idle_pct = 10;
        gen_count = 0;
        mismatches = 0;
        shadow_phase = '0;
        shadow_count = '0;
        for (p = 0; p < NUM_CH; p++)
            shadow_duty[p] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all channels active, cleared store, saturation, extremes
        write_channel_count(6'd32);
        add_cmd(mpwm_pkg::CMD_READ, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd31, 8'hFF, '1);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_SET_DUTY, 5'd0, 8'd255, '0);
        add_cmd(mpwm_pkg::CMD_SET_DUTY, 5'd31, 8'd31, '1);
        add_cmd(mpwm_pkg::CMD_SET_DUTY, 5'd5, 8'd32, '0);
        add_cmd(mpwm_pkg::CMD_SET_DUTY, 5'd1, 8'd1, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd5, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd31, 8'hFF, '1);
        add_cmd(mpwm_pkg::CMD_SET_PATTERN, 5'd0, 8'd0, '1);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_SET_PATTERN, 5'd0, 8'd0, 32'hA5A5_0F0F);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd2, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_SET_PATTERN, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        wait_drained();

        // Directed: no channels active
        write_channel_count(6'd0);
        add_cmd(mpwm_pkg::CMD_SET_PATTERN, 5'd0, 8'd0, '1);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_SET_DUTY, 5'd3, 8'd200, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd3, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd4, 8'd0, '0);
        wait_drained();

        // Directed: count beyond the channel limit
        write_channel_count(6'd63);
        add_cmd(mpwm_pkg::CMD_SET_PATTERN, 5'd0, 8'd0, 32'h8000_0001);
        add_cmd(mpwm_pkg::CMD_TICK, 5'd0, 8'd0, '0);
        add_cmd(mpwm_pkg::CMD_READ, 5'd31, 8'd0, '0);
        wait_drained();

        // Random phases: light sender gaps, heavy gaps, then back to back
        for (p = 0; p < 12; p++)
        begin
            idle_pct = (p < 4) ? 10 : ((p < 8) ? 49 : 0);
            write_channel_count(phase_counts[p]);
            gen_traffic(PHASE_ITEMS);
            wait_drained();
        end

        if (expected_out_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_out_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mpwm_pkg.sv
rtl/mpwm_duty_mem.sv
rtl/mpwm_seq.sv
rtl/multichannel_pwm_pattern_generator.sv
verif/tb_multichannel_pwm_pattern_generator.sv
